@@ rtl/sdspi_pkg.sv @@
// ----------------------------------------------------------------------------
// sdspi_pkg: SD SPI-mode card responder types and constants
// Modes, payload sources, command codes, fixed register tables.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_RX_CMD    = 4'd1,
        M_RX_BLOCK  = 4'd2,
        M_BUSY      = 4'd3,
        M_R1        = 4'd4,
        M_R3        = 4'd5,
        M_R7        = 4'd6,
        M_IMM32     = 4'd7,
        M_BLK_R1    = 4'd8,
        M_BLK_TOKEN = 4'd9,
        M_BLK_DATA  = 4'd10,
        M_WBLK_R1   = 4'd11,
        M_WBLK_STAT = 4'd12
    } t_mode;

    typedef enum logic [1:0] {
        SRC_BUFFER = 2'd0,
        SRC_CSD    = 2'd1,
        SRC_CID    = 2'd2,
        SRC_SCR    = 2'd3
    } t_src;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FILL  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [7:0] CMD0   = 8'h40;
    localparam logic [7:0] CMD8   = 8'h48;
    localparam logic [7:0] CMD9   = 8'h49;
    localparam logic [7:0] CMD10  = 8'h4a;
    localparam logic [7:0] CMD16  = 8'h50;
    localparam logic [7:0] CMD17  = 8'h51;
    localparam logic [7:0] CMD24  = 8'h58;
    localparam logic [7:0] CMD55  = 8'h77;
    localparam logic [7:0] CMD58  = 8'h7a;
    localparam logic [7:0] ACMD41 = 8'h69;
    localparam logic [7:0] ACMD51 = 8'h73;
    localparam logic [7:0] TOKEN  = 8'hfe;
    localparam logic [31:0] OCR   = 32'h4000_0000;

    // classified item handed from front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [8:0] idx;
    } t_item;

    function automatic logic [7:0] table_byte(t_src s, logic [9:0] i);
        logic [7:0] r;
        r = 8'h00;
        unique case (s)
            SRC_CSD: if (i < 10'd16) begin
                unique case (i[3:0])
                    4'd0: r = 8'h40;  4'd1: r = 8'h0e;  4'd3: r = 8'h32;
                    4'd4: r = 8'h5b;  4'd5: r = 8'h59;  4'd8: r = 8'h08;
                    4'd10: r = 8'h7f; 4'd11: r = 8'h80; 4'd12: r = 8'h0a;
                    4'd13: r = 8'h40; 4'd15: r = 8'h01;
                    default: r = 8'h00;
                endcase
            end
            SRC_CID: if (i < 10'd16) begin
                unique case (i[3:0])
                    4'd0: r = 8'h01; 4'd1: r = 8'h41; 4'd2: r = 8'h41;
                    4'd8: r = 8'h10; 4'd9: r = 8'h12; 4'd10: r = 8'h34;
                    4'd11: r = 8'h56; 4'd12: r = 8'h78;
                    4'd13, 4'd14, 4'd15: r = 8'h01;
                    default: r = 8'h42;
                endcase
            end
            SRC_SCR: if (i < 10'd8) begin
                unique case (i[2:0])
                    3'd0: r = 8'h01; 3'd1: r = 8'hb1; 3'd4: r = 8'h0c;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/sdspi_if.sv @@
// ----------------------------------------------------------------------------
// sdspi_in_if / sdspi_out_if: valid/ready channels
// Input item and result item transactions.
// ----------------------------------------------------------------------------
interface sdspi_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       chip_select;
    logic [7:0] data_byte;
    logic [8:0] fill_index;
    modport source (output valid, command, chip_select, data_byte, fill_index,
                    input ready);
    modport sink (input valid, command, chip_select, data_byte, fill_index,
                  output ready);
endinterface

interface sdspi_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_byte;
    logic        drives_output;
    logic        read_request;
    logic [31:0] request_block;
    modport source (output valid, read_byte, drives_output, read_request,
                    request_block, input ready);
    modport sink (input valid, read_byte, drives_output, read_request,
                  request_block, output ready);
endinterface

@@ rtl/sdspi_front.sv @@
// ----------------------------------------------------------------------------
// sdspi_front: input stage
// Accepts transactions, folds chip select into an operation code and
// queues them in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
module sdspi_front
    import sdspi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    sdspi_in_if.sink in_ch,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      n_it;
    logic       push;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign o_valid     = (r_cnt != 2'd0);
    assign o_item      = r_q[r_rp];

    always_comb begin
        n_it.data = in_ch.data_byte;
        n_it.idx  = in_ch.fill_index;
        priority if (in_ch.command == OP_FILL)
            n_it.op = OP_FILL;
        else if (in_ch.chip_select && in_ch.command == OP_WRITE)
            n_it.op = OP_WRITE;
        else if (in_ch.chip_select && in_ch.command == OP_READ)
            n_it.op = OP_READ;
        else
            n_it.op = OP_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
            r_q[0] <= '0; r_q[1] <= '0;
        end else begin
            if (push) r_q[r_wp] <= n_it;
            if (push) r_wp <= ~r_wp;
            if (i_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_take};
        end
    end

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_cnt != 2'd0) else $error("take from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !i_take |=> r_cnt == 2'd2) else $error("full queue lost entry");
endmodule

@@ rtl/sdspi_back.sv @@
// ----------------------------------------------------------------------------
// sdspi_back: protocol engine
// Two-phase per item: phase 0 issues the buffer read, phase 1 updates state
// and registers the result. A buffer clear sweep runs after reset.
// ----------------------------------------------------------------------------
module sdspi_back
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_item i_item,
    output logic o_take,
    sdspi_out_if.source out_ch
);
    localparam int AW = $clog2(BLOCK_BYTES);

    logic [7:0]  mem [BLOCK_BYTES];
    logic [7:0]  r_rd;
    t_mode       r_mode, r_pend;
    logic [7:0]  r_cb [6];
    logic [2:0]  r_cc;
    logic [9:0]  r_rp, r_len;
    logic [7:0]  r_st;
    logic [31:0] r_rw;
    t_src        r_src;
    logic        r_ph;
    logic        r_clr;
    logic [AW:0] r_cp;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_od, r_oq;
    logic [31:0] r_ok;

    t_mode       n_mode, n_pend;
    logic [2:0]  n_cc;
    logic [9:0]  n_rp, n_len;
    logic [7:0]  n_st, n_ob;
    logic [31:0] n_rw, n_ok;
    t_src        n_src;
    logic        n_od, n_oq, n_wcb;
    logic [7:0]  cb0;
    logic [31:0] arg;

    wire out_free = !r_ov || out_ch.ready;
    wire step     = i_valid && !r_clr && r_ph && out_free;
    assign o_take = step;

    assign out_ch.valid         = r_ov;
    assign out_ch.read_byte     = r_ob;
    assign out_ch.drives_output = r_od;
    assign out_ch.read_request  = r_oq;
    assign out_ch.request_block = r_ok;

    // command index and argument from the stored bytes; the current byte stands in as the first when none is stored
    always_comb begin
        cb0 = (r_cc == 3'd0) ? i_item.data : r_cb[0];
        arg = {r_cb[1], r_cb[2], r_cb[3], r_cb[4]};
    end

    always_comb begin
        logic [9:0] rp1;
        logic       start;
        logic       run;
        rp1 = r_rp + 10'd1;
        n_mode = r_mode; n_pend = r_pend; n_cc = r_cc; n_rp = r_rp;
        n_len = r_len; n_st = r_st; n_rw = r_rw; n_src = r_src;
        n_ob = 8'h00; n_od = 1'b0; n_oq = 1'b0; n_ok = 32'h0; n_wcb = 1'b0;
        start = 1'b0; run = 1'b0;
        unique case (i_item.op)
            OP_WRITE: begin
                n_ob = 8'hff; n_od = 1'b1;
                unique case (r_mode)
                    M_RX_CMD: run = 1'b1;
                    M_RX_BLOCK: begin
                        if (r_rp == 10'd0) begin
                            if (i_item.data != TOKEN) begin
                                n_mode = M_IDLE; n_cc = 3'd0; n_len = 10'd0;
                            end
                        end else if (r_rp >= 10'(BLOCK_BYTES + 2)) begin
                            n_st = 8'h05; n_mode = M_WBLK_STAT;
                        end
                        n_rp = rp1;
                    end
                    M_BUSY: ;
                    default: begin
                        if (i_item.data[7:6] != 2'b01) n_od = 1'b0;
                        else begin
                            start = 1'b1; run = 1'b1;
                        end
                    end
                endcase
                if (start) begin
                    n_mode = M_RX_CMD; n_rp = 10'd0; n_len = 10'd0;
                end
                if (run) begin
                    if (start || r_cc < 3'd6) begin
                        n_wcb = 1'b1;
                        n_cc  = start ? 3'd1 : r_cc + 3'd1;
                    end
                    if (!start && r_cc >= 3'd5) begin
                        n_rp = 10'd0; n_mode = M_BUSY;
                        priority case (cb0)
                            CMD0:  begin n_st = 8'h01; n_pend = M_R1; end
                            CMD8:  begin n_rw = arg; n_st = 8'h01; n_pend = M_R7; end
                            CMD9:  begin n_len = 10'd16; n_src = SRC_CSD;
                                   n_st = 8'h00; n_pend = M_BLK_R1; end
                            CMD10: begin n_len = 10'd16; n_src = SRC_CID;
                                   n_st = 8'h00; n_pend = M_BLK_R1; end
                            CMD16: begin n_st = (r_cb[3] != 8'd2) ? 8'h05 : 8'h01;
                                   n_pend = M_R1; end
                            CMD17: begin n_len = 10'(BLOCK_BYTES); n_src = SRC_BUFFER;
                                   n_st = 8'h00; n_pend = M_BLK_R1;
                                   n_oq = 1'b1; n_ok = arg; end
                            CMD24: begin n_len = 10'd0; n_st = 8'h00;
                                   n_pend = M_WBLK_R1; end
                            CMD55: begin n_st = 8'h01; n_pend = M_R1; end
                            CMD58: begin n_rw = OCR; n_st = 8'h00; n_pend = M_R3; end
                            ACMD41: begin n_st = 8'h00; n_pend = M_R1; end
                            ACMD51: begin n_len = 10'd8; n_src = SRC_SCR;
                                   n_st = 8'h00; n_pend = M_BLK_R1; end
                            default: begin n_st = 8'h05; n_pend = M_R1; end
                        endcase
                    end
                end
            end
            OP_READ: begin
                n_ob = 8'hff; n_od = 1'b1;
                unique case (r_mode)
                    M_RX_CMD: begin
                        n_mode = M_IDLE; n_cc = 3'd0; n_rp = 10'd0; n_len = 10'd0;
                    end
                    M_BUSY: begin n_mode = r_pend; n_pend = M_IDLE; end
                    M_R1: begin n_ob = r_st; n_mode = r_pend; n_pend = M_IDLE; end
                    M_R3, M_R7: begin n_ob = r_st; n_mode = M_IMM32; n_pend = M_IDLE; end
                    M_IMM32: begin
                        unique case (r_rp[1:0])
                            2'd0: n_ob = r_rw[31:24];
                            2'd1: n_ob = r_rw[23:16];
                            2'd2: n_ob = r_rw[15:8];
                            default: n_ob = r_rw[7:0];
                        endcase
                        n_rp = rp1;
                        if (rp1 >= 10'd4) n_mode = M_IDLE;
                    end
                    M_BLK_R1: begin n_ob = r_st; n_mode = M_BLK_TOKEN; end
                    M_BLK_TOKEN: begin n_ob = TOKEN; n_mode = M_BLK_DATA; end
                    M_BLK_DATA: begin
                        if (r_rp < r_len)
                            n_ob = (r_src == SRC_BUFFER) ? r_rd : table_byte(r_src, r_rp);
                        else begin
                            n_ob = 8'h00;
                            if (r_rp != r_len) n_mode = M_IDLE;
                        end
                        n_rp = rp1;
                    end
                    M_WBLK_R1: begin
                        n_ob = r_st; n_cc = 3'd0; n_rp = 10'd0; n_len = 10'd0;
                        n_mode = M_RX_BLOCK;
                    end
                    M_WBLK_STAT: begin n_ob = r_st; n_mode = M_IDLE; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // buffer: one write port (fill or clear), one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr)
            mem[r_cp[AW-1:0]] <= 8'h00;
        else if (step && i_item.op == OP_FILL)
            mem[i_item.idx[AW-1:0]] <= i_item.data;
        r_rd <= mem[r_rp[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_ob <= n_ob; r_od <= n_od; r_oq <= n_oq; r_ok <= n_ok;
        end
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pend <= M_IDLE; r_cc <= 3'd0; r_rp <= 10'd0;
            r_len <= 10'd0; r_ph <= 1'b0; r_clr <= 1'b1; r_cp <= '0; r_ov <= 1'b0;
            r_src <= SRC_BUFFER; r_st <= 8'h00; r_rw <= 32'h0;
            for (int k = 0; k < 6; k++) r_cb[k] <= 8'h00;
        end else begin
            if (step && n_wcb) r_cb[n_cc - 3'd1] <= i_item.data;
            if (r_clr) begin
                r_cp <= r_cp + 1'b1;
                if (r_cp == (AW+1)'(BLOCK_BYTES - 1)) r_clr <= 1'b0;
            end
            if (step) begin
                r_mode <= n_mode; r_pend <= n_pend; r_cc <= n_cc;
                r_rp <= n_rp; r_len <= n_len;
                r_rw <= n_rw; r_st <= n_st; r_src <= n_src;
                r_ph <= 1'b0;
            end else if (i_valid && !r_clr) r_ph <= 1'b1;
            if (step) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
        end
    end

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_take) else $error("item taken during clear");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> out_ch.valid) else $error("result lost");
    a_req_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && n_oq) |-> i_item.op == OP_WRITE) else $error("bad read request");
endmodule

@@ rtl/sd_card_spi_responder_core.sv @@
// ----------------------------------------------------------------------------
// sd_card_spi_responder_core: SD card side of SPI mode
// Front queue plus protocol engine with a 512-byte block buffer.
// ----------------------------------------------------------------------------
// The protocol engine handles each input transaction in a read phase, which
// reads the block buffer at the response pointer, then an update phase, which
// updates state and loads the result register; it takes no new item before
// the last is through, and output back-pressure can hold the update phase.
// A two-entry queue decouples input from the engine. After reset the buffer
// is cleared by a sweep; meanwhile no item is processed (items still queue).
module sd_card_spi_responder_core
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
) (
    input logic i_clk,
    input logic i_rst_n,
    sdspi_in_if.sink   in_ch,
    sdspi_out_if.source out_ch
);
    logic  q_valid, q_take;
    t_item q_item;

    sdspi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_valid(q_valid), .o_item(q_item), .i_take(q_take)
    );

    sdspi_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_take(q_take), .out_ch(out_ch)
    );
endmodule

@@ test/sd_card_spi_responder_core_tb.sv @@
// ----------------------------------------------------------------------------
// sd_card_spi_responder_core_tb: SD SPI card responder testbench
// Drives host write/read and buffer fill transactions, predicts each result
// with a behavioral card model and checks every result transaction in order.
// ----------------------------------------------------------------------------
module sd_card_spi_responder_core_tb;
    import sdspi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_BYTES = 512;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        drives_output;
        logic        read_request;
        logic [31:0] request_block;
    } t_card_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sdspi_in_if  in_ch ();
    sdspi_out_if out_ch ();

    sd_card_spi_responder_core #(.BLOCK_BYTES(BLOCK_BYTES)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // card state mirror
    t_mode        card_mode;
    t_mode        card_next_mode;
    logic [7:0]   cmd_buf [6];
    int unsigned  cmd_cnt;
    logic [9:0]   rsp_idx;
    logic [9:0]   xfer_len;
    logic [7:0]   status;
    logic [31:0]  reply;
    t_src         src;
    logic [7:0]   blk_buf [BLOCK_BYTES];

    t_card_result expected_results [$];
    t_card_result exp_res, act_res;
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           items_sent = 0;
    int           out_wait = 0;
    int           out_draw;
    bit           stimulus_done = 0;

    function automatic logic [7:0] fixed_payload(t_src s, logic [9:0] i);
        logic [7:0] csd [16] = '{8'h40, 8'h0e, 8'h00, 8'h32, 8'h5b, 8'h59, 8'h00, 8'h00,
                                 8'h08, 8'h00, 8'h7f, 8'h80, 8'h0a, 8'h40, 8'h00, 8'h01};
        logic [7:0] cid [16] = '{8'h01, 8'h41, 8'h41, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42,
                                 8'h10, 8'h12, 8'h34, 8'h56, 8'h78, 8'h01, 8'h01, 8'h01};
        logic [7:0] scr [8] = '{8'h01, 8'hb1, 8'h00, 8'h00, 8'h0c, 8'h00, 8'h00, 8'h00};
        case (s)
            SRC_CSD: return i < 16 ? csd[i] : 8'h00;
            SRC_CID: return i < 16 ? cid[i] : 8'h00;
            SRC_SCR: return i < 8 ? scr[i] : 8'h00;
            default: return i < BLOCK_BYTES ? blk_buf[i] : 8'h00;
        endcase
    endfunction

    function automatic void clear_ptrs();
        cmd_cnt = 0;
        rsp_idx = '0;
        xfer_len = '0;
    endfunction

    function automatic void start_answer(t_mode nxt, logic [7:0] st);
        rsp_idx = '0;
        status = st;
        card_next_mode = nxt;
        card_mode = M_BUSY;
    endfunction

    function automatic void card_reset();
        card_mode = M_IDLE;
        card_next_mode = M_IDLE;
        foreach (cmd_buf[i]) cmd_buf[i] = '0;
        clear_ptrs();
        status = '0;
        reply = '0;
        src = SRC_BUFFER;
        foreach (blk_buf[i]) blk_buf[i] = '0;
    endfunction

    function automatic t_card_result host_write(logic [7:0] d);
        t_card_result r;
        logic [31:0] arg;
        r = '{8'hff, 1'b1, 1'b0, 32'h0};
        case (card_mode)
            M_BUSY: return r;
            M_RX_BLOCK: begin
                if (rsp_idx == 0) begin
                    if (d != TOKEN) begin
                        card_mode = M_IDLE;
                        clear_ptrs();
                    end
                end else if (rsp_idx >= BLOCK_BYTES + 2) begin
                    status = 8'h05;
                    card_mode = M_WBLK_STAT;
                end
                rsp_idx = rsp_idx + 10'd1;
                return r;
            end
            M_RX_CMD: ;
            M_IDLE, M_R1, M_R3, M_R7, M_IMM32, M_BLK_R1, M_BLK_TOKEN, M_BLK_DATA,
            M_WBLK_R1, M_WBLK_STAT: begin
                if (d[7:6] != 2'b01) begin
                    r.drives_output = 1'b0;
                    return r;
                end
                card_mode = M_RX_CMD;
                clear_ptrs();
            end
            default: return r;
        endcase
        if (cmd_cnt < 6) begin
            cmd_buf[cmd_cnt] = d;
            cmd_cnt++;
        end
        if (cmd_cnt < 6) return r;
        arg = {cmd_buf[1], cmd_buf[2], cmd_buf[3], cmd_buf[4]};
        case (cmd_buf[0])
            CMD0: start_answer(M_R1, 8'h01);
            CMD8: begin reply = arg; start_answer(M_R7, 8'h01); end
            CMD9: begin
                xfer_len = 10'd16; src = SRC_CSD; start_answer(M_BLK_R1, 8'h00);
            end
            CMD10: begin
                xfer_len = 10'd16; src = SRC_CID; start_answer(M_BLK_R1, 8'h00);
            end
            CMD16: start_answer(M_R1, cmd_buf[3] != 2 ? 8'h05 : 8'h01);
            CMD17: begin
                r.read_request = 1'b1;
                r.request_block = arg;
                xfer_len = 10'(BLOCK_BYTES);
                src = SRC_BUFFER;
                start_answer(M_BLK_R1, 8'h00);
            end
            CMD24: begin xfer_len = '0; start_answer(M_WBLK_R1, 8'h00); end
            CMD55: start_answer(M_R1, 8'h01);
            CMD58: begin reply = OCR; start_answer(M_R3, 8'h00); end
            ACMD41: start_answer(M_R1, 8'h00);
            ACMD51: begin
                xfer_len = 10'd8; src = SRC_SCR; start_answer(M_BLK_R1, 8'h00);
            end
            default: start_answer(M_R1, 8'h05);
        endcase
        return r;
    endfunction

    function automatic logic [7:0] host_read();
        logic [7:0] r;
        r = 8'hff;
        case (card_mode)
            M_RX_CMD: begin card_mode = M_IDLE; clear_ptrs(); end
            M_BUSY: begin card_mode = card_next_mode; card_next_mode = M_IDLE; end
            M_R1, M_R3, M_R7: begin
                if (card_mode != M_R1) card_next_mode = M_IMM32;
                r = status;
                card_mode = card_next_mode;
                card_next_mode = M_IDLE;
            end
            M_IMM32: begin
                r = 8'(reply >> (8 * (3 - rsp_idx[1:0])));
                rsp_idx = rsp_idx + 10'd1;
                if (rsp_idx >= 4) card_mode = M_IDLE;
            end
            M_BLK_R1: begin r = status; card_mode = M_BLK_TOKEN; end
            M_BLK_TOKEN: begin r = TOKEN; card_mode = M_BLK_DATA; end
            M_BLK_DATA: begin
                if (rsp_idx < xfer_len) r = fixed_payload(src, rsp_idx);
                else begin
                    r = 8'h00;
                    if (rsp_idx != xfer_len) card_mode = M_IDLE;
                end
                rsp_idx = rsp_idx + 10'd1;
            end
            M_WBLK_R1: begin r = status; clear_ptrs(); card_mode = M_RX_BLOCK; end
            M_WBLK_STAT: begin r = status; card_mode = M_IDLE; end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_card_result predict_card(t_op op, logic cs, logic [7:0] d,
                                                  logic [8:0] fi);
        t_card_result r;
        r = '0;
        if (op == OP_FILL) blk_buf[fi] = d;
        else if (op == OP_WRITE && cs) r = host_write(d);
        else if (op == OP_READ && cs) begin
            r.read_byte = host_read();
            r.drives_output = 1'b1;
        end
        return r;
    endfunction

    task automatic send_item(t_op op, logic cs, logic [7:0] d, logic [8:0] fi);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= op;
        in_ch.chip_select <= cs;
        in_ch.data_byte <= d;
        in_ch.fill_index <= fi;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results.push_back(predict_card(op, cs, d, fi));
        items_sent++;
    endtask

    task automatic host_wr(logic [7:0] d);
        send_item(OP_WRITE, 1'b1, d, 9'($urandom));
    endtask

    task automatic host_rd(int n);
        repeat (n) send_item(OP_READ, 1'b1, 8'($urandom), 9'($urandom));
    endtask

    task automatic send_cmd(logic [7:0] c, logic [31:0] arg);
        host_wr(c);
        for (int i = 3; i >= 0; i--) host_wr(arg[8*i +: 8]);
        host_wr(8'h95);
    endtask

    task automatic test_directed();
        send_item(OP_NONE, 1'b1, 8'hff, 9'h1ff);
        send_item(OP_WRITE, 1'b0, 8'h40, 9'h0);
        send_item(OP_READ, 1'b0, 8'h00, 9'h0);
        host_wr(8'hff);
        send_cmd(CMD0, 32'h0);
        host_wr(8'h00);
        host_rd(3);
        send_cmd(CMD8, 32'h0000_01aa);
        host_rd(7);
        host_wr(8'h48);
        host_rd(1);
    endtask

    task automatic test_registers();
        send_cmd(CMD58, 32'h0);
        host_rd(7);
        send_cmd(CMD9, 32'h0);
        host_rd(22);
        send_cmd(CMD10, 32'h0);
        host_rd(22);
        send_cmd(CMD55, 32'h0);
        host_rd(2);
        send_cmd(ACMD51, 32'h0);
        host_rd(14);
        send_cmd(CMD16, 32'h0000_0200);
        host_rd(2);
        send_cmd(CMD16, 32'h0000_0000);
        host_rd(2);
        send_cmd(ACMD41, 32'h4000_0000);
        host_rd(2);
        send_cmd(8'h7f, 32'hffff_ffff);
        host_rd(2);
    endtask

    task automatic test_block_read(int nfill);
        logic [31:0] blk;
        blk = $urandom_range(0, 1) ? 32'hffff_ffff : $urandom;
        send_cmd(CMD17, blk);
        repeat (nfill)
            send_item(OP_FILL, 1'($urandom_range(0, 1)), 8'($urandom), 9'($urandom));
        host_rd($urandom_range(3, 6) + 20);
    endtask

    task automatic test_block_write(bit good_token);
        send_cmd(CMD24, $urandom);
        host_rd(2);
        host_wr(good_token ? TOKEN : 8'($urandom_range(0, 253)));
        if (good_token) begin
            repeat (BLOCK_BYTES + 2) host_wr(8'($urandom));
            host_wr(8'hff);
            host_rd(2);
        end
    endtask

    task automatic test_random(int total);
        while (items_sent < total) begin
            case ($urandom_range(0, 9))
                0: test_block_read($urandom_range(0, 12));
                1: if ($urandom_range(0, 3) == 0) test_block_write(1'b0);
                2, 3: begin
                    send_cmd(8'h40 | 8'($urandom_range(0, 63)), $urandom);
                    host_rd($urandom_range(1, 8));
                end
                4: begin
                    host_wr(8'h40 | 8'($urandom_range(0, 63)));
                    host_wr(8'($urandom));
                    host_rd(1);
                end
                default: begin
                    send_item(t_op'($urandom_range(0, 3)), $urandom_range(0, 3) != 0,
                              8'($urandom), 9'($urandom));
                end
            endcase
        end
    endtask

    // result checker; ready held off for a random wait before each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_wait <= $urandom_range(0, 8);
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                out_draw = $urandom_range(0, 8);
                out_wait <= out_draw;
                out_ch.ready <= (out_draw == 0);
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transaction");
                end else begin
                    exp_res = expected_results.pop_front();
                    act_res = '{out_ch.read_byte, out_ch.drives_output,
                                out_ch.read_request, out_ch.request_block};
                    if (act_res !== exp_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp byte %h drv %b req %b blk %h, got %h %b %b %h",
                                     exp_res.read_byte, exp_res.drives_output,
                                     exp_res.read_request, exp_res.request_block,
                                     act_res.read_byte, act_res.drives_output,
                                     act_res.read_request, act_res.request_block);
                    end
                end
            end else if (out_wait > 0) begin
                out_wait <= out_wait - 1;
                out_ch.ready <= (out_wait == 1);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on accepted transactions
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (stimulus_done && expected_results.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = OP_NONE;
        in_ch.chip_select = 1'b0;
        in_ch.data_byte = '0;
        in_ch.fill_index = '0;
        out_ch.ready = 1'b0;
        card_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_registers();
        test_block_read(4);
        test_block_write(1'b1);
        test_block_write(1'b0);
        test_random(780);
        stimulus_done = 1;
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
